// ===== rtl/u8u16_pkg.sv =====
package u8u16_pkg;

  localparam int QueueDepth = 4;

  localparam logic [15:0] ReplUnit = 16'hFFFD;
  localparam logic [15:0] HiSurrBase = 16'hD800;
  localparam logic [15:0] LoSurrBase = 16'hDC00;

  localparam logic [20:0] BomCode = 21'h00FEFF;
  localparam logic [20:0] SuppBase = 21'h010000;
  localparam logic [20:0] CodeLimit = 21'h110000;
  localparam logic [20:0] SurrFirst = 21'h00D800;
  localparam logic [20:0] SurrLast = 21'h00DFFF;
  localparam logic [20:0] MinTwoByte = 21'h000080;
  localparam logic [20:0] MinThreeByte = 21'h000800;
  localparam logic [20:0] MinFourByte = 21'h010000;

  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } lead_kind_t;

  // one item's results: pre replacements, up to two decoded units, post replacements
  typedef struct packed {
    logic [1:0]  pre;
    logic [1:0]  body;
    logic [2:0]  cnt;
    logic [15:0] unit0;
    logic        bad0;
    logic [15:0] unit1;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== rtl/utf8_to_utf16_decoder.sv =====
// path: an item's results pass through the result queue, then each code unit through the output register
// throughput: one byte per cycle while the 4-entry result queue has room, one code unit per cycle
// at the output while results are queued and out_ready is high; bytes giving up to 4 units drain from the queue
// reset: synchronous, clears the decoder state, the queue and the output valid
module utf8_to_utf16_decoder #(
  parameter int Depth = u8u16_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_in,
  input  logic        end_of_string,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] code_unit,
  output logic        was_invalid,
  output logic        last_of_run
);
  import u8u16_pkg::*;

  desc_t      wr_desc;
  desc_t      head;
  fifo_stat_t stat;
  logic       push;
  logic       pop;

  u8u16_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .byte_in       (byte_in),
    .end_of_string (end_of_string),
    .stat          (stat),
    .push          (push),
    .desc          (wr_desc)
  );

  u8u16_fifo #(
    .Depth (Depth)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_desc),
    .pop     (pop),
    .head    (head),
    .stat    (stat)
  );

  u8u16_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .stat        (stat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code_unit   (code_unit),
    .was_invalid (was_invalid),
    .last_of_run (last_of_run)
  );

endmodule

// ===== rtl/u8u16_front.sv =====
module u8u16_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             byte_in,
  input  logic                   end_of_string,
  input  u8u16_pkg::fifo_stat_t  stat,
  output logic                   push,
  output u8u16_pkg::desc_t       desc
);
  import u8u16_pkg::*;

  logic [1:0]  bytes_remaining;
  logic [1:0]  sequence_length;
  logic [20:0] partial_code;
  logic        header_seen;

  logic [1:0]  bytes_remaining_next;
  logic [1:0]  sequence_length_next;
  logic [20:0] partial_code_next;
  logic        header_seen_next;

  lead_kind_t  kind;
  logic        cont;
  logic [20:0] shifted;
  logic [1:0]  rem_dec;
  logic        accept;

  logic        l_body;
  logic [15:0] l_unit;
  logic        l_bad;
  logic        l_open;
  logic        l_hs;
  logic [20:0] l_bits;
  logic [1:0]  l_need;

  logic [1:0]  f_n;
  logic [15:0] f_unit0;
  logic        f_bad0;
  logic [15:0] f_unit1;
  logic [20:0] v;
  logic [20:0] min_cp;
  logic        nonch;

  logic [1:0]  pre;
  logic [1:0]  body;
  logic [1:0]  post;
  logic        hs_base;

  assign in_ready = !stat.full;
  assign accept   = in_valid && in_ready;
  assign cont     = (byte_in[7:6] == 2'b10);
  assign shifted  = {partial_code[14:0], byte_in[5:0]};
  assign rem_dec  = bytes_remaining - 2'd1;

  always_comb begin
    if (!byte_in[7]) begin
      kind = LEAD_ASCII;
    end else if (byte_in[7:5] == 3'b110) begin
      kind = LEAD_TWO;
    end else if (byte_in[7:4] == 4'b1110) begin
      kind = LEAD_THREE;
    end else if (byte_in[7:3] == 5'b11110) begin
      kind = LEAD_FOUR;
    end else begin
      kind = LEAD_BAD;
    end
  end

  always_comb begin
    l_body = 1'b0;
    l_unit = {8'h00, byte_in};
    l_bad  = 1'b0;
    l_open = 1'b0;
    l_hs   = 1'b1;
    l_bits = '0;
    l_need = 2'd0;
    case (kind)
      LEAD_ASCII: begin
        l_body = 1'b1;
      end
      LEAD_TWO: begin
        l_open = 1'b1;
        l_bits = {16'h0000, byte_in[4:0]};
        l_need = 2'd1;
      end
      LEAD_THREE: begin
        l_open = 1'b1;
        l_bits = {17'h00000, byte_in[3:0]};
        l_need = 2'd2;
        l_hs   = 1'b0;
      end
      LEAD_FOUR: begin
        l_open = 1'b1;
        l_bits = {18'h00000, byte_in[2:0]};
        l_need = 2'd3;
      end
      default: begin
        l_body = 1'b1;
        l_unit = ReplUnit;
        l_bad  = 1'b1;
      end
    endcase
  end

  // completion of a multi-byte sequence
  always_comb begin
    case (sequence_length)
      2'd1:    min_cp = MinTwoByte;
      2'd2:    min_cp = MinThreeByte;
      2'd3:    min_cp = MinFourByte;
      default: min_cp = '0;
    endcase
    nonch   = (shifted[15:1] == 15'h7FFF) || (shifted[20:4] == 17'h00FDD);
    v       = shifted - SuppBase;
    f_unit1 = LoSurrBase + {6'b0, v[9:0]};
    f_n     = 2'd1;
    f_unit0 = shifted[15:0];
    f_bad0  = 1'b0;
    if (!header_seen && shifted == BomCode) begin
      f_n = 2'd0;
    end else if (!nonch && shifted >= SuppBase && shifted < CodeLimit) begin
      f_n     = 2'd2;
      f_unit0 = HiSurrBase + {6'b0, v[19:10]};
    end else if (shifted < min_cp || (shifted >= SurrFirst && shifted <= SurrLast) ||
                 nonch || shifted >= CodeLimit) begin
      f_unit0 = ReplUnit;
      f_bad0  = 1'b1;
    end
  end

  always_comb begin
    pre                  = 2'd0;
    body                 = 2'd0;
    post                 = 2'd0;
    hs_base              = header_seen;
    desc.unit0           = l_unit;
    desc.bad0            = l_bad;
    desc.unit1           = f_unit1;
    bytes_remaining_next = bytes_remaining;
    sequence_length_next = sequence_length;
    partial_code_next    = partial_code;
    header_seen_next     = header_seen;
    if (bytes_remaining != 2'd0 && cont) begin
      partial_code_next    = shifted;
      bytes_remaining_next = rem_dec;
      if (rem_dec == 2'd0) begin
        body             = f_n;
        desc.unit0       = f_unit0;
        desc.bad0        = f_bad0;
        header_seen_next = 1'b1;
      end else if (end_of_string) begin
        post = 2'd1 + (sequence_length - rem_dec);
      end
    end else begin
      if (bytes_remaining != 2'd0) begin
        pre     = 2'd1 + (sequence_length - bytes_remaining);
        hs_base = 1'b1;
      end
      body                 = {1'b0, l_body};
      header_seen_next     = hs_base | l_hs;
      bytes_remaining_next = 2'd0;
      if (l_open) begin
        partial_code_next    = l_bits;
        bytes_remaining_next = l_need;
        sequence_length_next = l_need;
        if (end_of_string) begin
          post = 2'd1;
        end
      end
    end
    if (end_of_string) begin
      bytes_remaining_next = 2'd0;
      sequence_length_next = 2'd0;
      partial_code_next    = '0;
      header_seen_next     = 1'b0;
    end
    desc.pre  = pre;
    desc.body = body;
    desc.cnt  = {1'b0, pre} + {1'b0, body} + {1'b0, post};
  end

  assign push = accept && (desc.cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= '0;
      sequence_length <= '0;
      partial_code    <= '0;
      header_seen     <= 1'b0;
    end else if (accept) begin
      bytes_remaining <= bytes_remaining_next;
      sequence_length <= sequence_length_next;
      partial_code    <= partial_code_next;
      header_seen     <= header_seen_next;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    push |-> desc.cnt <= 3'd4)
    else $error("item result count out of range");

  a_rem_le_len: assert property (@(posedge clk) disable iff (rst)
    bytes_remaining <= sequence_length)
    else $error("remaining bytes exceed sequence length");

  a_eos_reset: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_string |=> bytes_remaining == 2'd0 && !header_seen)
    else $error("state not cleared after last byte");

endmodule

// ===== rtl/u8u16_fifo.sv =====
module u8u16_fifo #(
  parameter int Depth = u8u16_pkg::QueueDepth
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  u8u16_pkg::desc_t      wr_data,
  input  logic                  pop,
  output u8u16_pkg::desc_t      head,
  output u8u16_pkg::fifo_stat_t stat
);
  import u8u16_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  desc_t            mem [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign head       = mem[rd_ptr];
  assign stat.full  = (count == CntW'(Depth));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/u8u16_back.sv =====
module u8u16_back (
  input  logic                  clk,
  input  logic                  rst,
  input  u8u16_pkg::desc_t      head,
  input  u8u16_pkg::fifo_stat_t stat,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           code_unit,
  output logic                  was_invalid,
  output logic                  last_of_run
);
  import u8u16_pkg::*;

  logic [1:0]  idx;
  logic [2:0]  kk;
  logic [2:0]  pre3;
  logic [2:0]  body_end;
  logic        load;
  logic        is_last;
  logic [15:0] sel_unit;
  logic        sel_bad;

  assign kk       = {1'b0, idx};
  assign pre3     = {1'b0, head.pre};
  assign body_end = pre3 + {1'b0, head.body};
  assign load     = !stat.empty && (!out_valid || out_ready);
  assign is_last  = (kk == head.cnt - 3'd1);
  assign pop      = load && is_last;

  always_comb begin
    if (kk < pre3 || kk >= body_end) begin
      sel_unit = ReplUnit;
      sel_bad  = 1'b1;
    end else if (kk == pre3) begin
      sel_unit = head.unit0;
      sel_bad  = head.bad0;
    end else begin
      sel_unit = head.unit1;
      sel_bad  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= is_last ? 2'd0 : idx + 2'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_unit   <= sel_unit;
      was_invalid <= sel_bad;
      last_of_run <= is_last;
    end
  end

  a_head_nonempty: assert property (@(posedge clk) disable iff (rst)
    !stat.empty |-> head.cnt != 3'd0 && head.cnt <= 3'd4)
    else $error("queued item has no results");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    !stat.empty |-> kk < head.cnt)
    else $error("result index past item end");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run |=> out_valid)
    else $error("item results interrupted");

endmodule
